// File: src/rmeu_pkg.sv
// ----------------------------------------------------------------------------
// Register machine execute unit package
// Shared types, opcodes, status codes and constants for the execute unit.
// ----------------------------------------------------------------------------
package rmeu_pkg;

  localparam int unsigned PROGRAM_DEPTH = 1024;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned LIT_W         = 31;
  localparam int unsigned REG_SEL_W     = 3;
  localparam int unsigned INDEX_W       = 11;
  localparam int unsigned TARGET_W      = 10;
  localparam int unsigned REG_COUNT     = 5;
  localparam int unsigned REG_ADDR_W    = $clog2(REG_COUNT);
  localparam int unsigned STEP_CNT_W    = $clog2(DATA_W);
  localparam logic [INDEX_W-1:0] LEN_RESET = INDEX_W'(1);

  // Instruction opcodes
  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_MOV       = 4'd1,
    OP_ADD       = 4'd2,
    OP_SUB       = 4'd3,
    OP_MUL       = 4'd4,
    OP_DIV       = 4'd5,
    OP_CMP       = 4'd6,
    OP_JMP       = 4'd7,
    OP_JE        = 4'd8,
    OP_JG        = 4'd9,
    OP_JL        = 4'd10,
    OP_JNE       = 4'd11,
    OP_JGE       = 4'd12,
    OP_JLE       = 4'd13,
    OP_PRINTINT  = 4'd14,
    OP_PRINTCHAR = 4'd15
  } op_e;

  // Completion status
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_LIT_DST  = 2'd1,
    STAT_DIV_ZERO = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_EXEC,
    ST_MUL,
    ST_DIV_PREP,
    ST_DIV,
    ST_DIV_FIX,
    ST_FINISH
  } state_e;

  // Decoded instruction
  typedef struct packed {
    op_e                 operation;
    logic [REG_SEL_W-1:0] left_reg;
    logic                left_is_literal;
    logic [LIT_W-1:0]    left_literal;
    logic [REG_SEL_W-1:0] right_reg;
    logic                right_is_literal;
    logic [LIT_W-1:0]    right_literal;
    logic [TARGET_W-1:0] jump_target;
  } in_item_t;

  // Execution result
  typedef struct packed {
    logic [INDEX_W-1:0]       next_index;
    logic                     program_done;
    logic                     print_valid;
    logic                     print_is_char;
    logic signed [DATA_W-1:0] print_value;
    status_e                  status;
  } out_item_t;

  // Register select 5..7 maps onto r5
  function automatic logic [REG_ADDR_W-1:0] sel_reg(input logic [REG_SEL_W-1:0] r);
    logic [REG_ADDR_W-1:0] res;
    if (32'(r) > REG_COUNT - 1) begin
      res = REG_ADDR_W'(REG_COUNT - 1);
    end else begin
      res = REG_ADDR_W'(r);
    end
    return res;
  endfunction

endpackage

// File: src/rmeu_in_if.sv
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel carrying one decoded instruction per transaction.
// ----------------------------------------------------------------------------
interface rmeu_in_if import rmeu_pkg::*; ();

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// File: src/rmeu_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one execution result per transaction.
// ----------------------------------------------------------------------------
interface rmeu_out_if import rmeu_pkg::*; ();

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// File: src/register_machine_execute_unit_top.sv
// The unit takes one instruction at a time and accepts the next only once
//   the result is registered.
// Mul and div step one bit per cycle through the shared 33-bit adder.
// Reset (rst_ni, async, active low): r1..r5, flags and index cleared,
//   program_length set to 1, no result pending.
// ----------------------------------------------------------------------------
// Register machine execute unit
// Executes decoded instructions on a five-register machine with a small
// sequencer around one shared add/subtract unit.
// ----------------------------------------------------------------------------
module register_machine_execute_unit_top import rmeu_pkg::*; #(
  parameter int unsigned ProgramDepth = PROGRAM_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [INDEX_W-1:0] cfg_wdata_i,
  rmeu_in_if.sink            item_i,
  rmeu_out_if.source         result_o
);

  // Control state
  state_e                 state_q, state_d;
  logic [STEP_CNT_W-1:0]  cnt_q, cnt_d;
  logic [INDEX_W-1:0]     index_q, index_d;
  logic [INDEX_W-1:0]     len_q;
  logic                   zero_q, zero_d;
  logic                   less_q, less_d;
  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      rf_q [REG_COUNT];

  // Datapath registers
  in_item_t               in_q;
  logic [DATA_W-1:0]      rdata_q;
  logic [DATA_W-1:0]      a_q, a_d;
  logic [DATA_W-1:0]      work_q, work_d;
  logic [DATA_W-1:0]      opnd_q, opnd_d;
  logic [DATA_W-1:0]      shift_q, shift_d;
  logic                   neg_q, neg_d;
  logic                   hold_q, hold_d;
  logic                   take_q, take_d;
  status_e                status_q, status_d;
  logic                   pvalid_q, pvalid_d;
  logic                   pchar_q, pchar_d;
  logic [DATA_W-1:0]      pval_q, pval_d;
  out_item_t              out_q, out_d;

  logic                   accept;
  logic                   out_load;
  logic [REG_ADDR_W-1:0]  rd_addr;
  logic [REG_ADDR_W-1:0]  dst;
  logic [DATA_W-1:0]      b_val;
  logic [INDEX_W-1:0]     len_eff;
  logic [INDEX_W-1:0]     next_idx;

  logic                   rf_we;
  logic [REG_ADDR_W-1:0]  rf_waddr;
  logic [DATA_W-1:0]      rf_wdata;

  // Shared add/subtract unit
  logic [DATA_W:0]        alu_a, alu_b, alu_sum;
  logic                   alu_sub;

  assign accept       = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == ST_IDLE);
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // Effective program length, clamped to the program depth
  assign len_eff = (32'(len_q) > 32'(ProgramDepth)) ? INDEX_W'(ProgramDepth) : len_q;

  assign rd_addr = (state_q == ST_IDLE) ? sel_reg(item_i.payload.left_reg)
                                        : sel_reg(in_q.right_reg);
  assign dst     = sel_reg(in_q.left_reg);
  assign b_val   = in_q.right_is_literal ? {1'b0, in_q.right_literal} : rdata_q;

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + (DATA_W + 1)'(alu_sub);

  // Next index: stay on error or finished program, else branch or fall through
  always_comb begin
    if (hold_q) begin
      next_idx = index_q;
    end else if (take_q) begin
      next_idx = INDEX_W'(in_q.jump_target) + INDEX_W'(1);
    end else begin
      next_idx = index_q + INDEX_W'(1);
    end
  end

  // Sequencer: next state, unit operand select and register updates
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    index_d     = index_q;
    zero_d      = zero_q;
    less_d      = less_q;
    a_d         = a_q;
    work_d      = work_q;
    opnd_d      = opnd_q;
    shift_d     = shift_q;
    neg_d       = neg_q;
    hold_d      = hold_q;
    take_d      = take_q;
    status_d    = status_q;
    pvalid_d    = pvalid_q;
    pchar_d     = pchar_q;
    pval_d      = pval_q;
    out_d       = out_q;
    out_load    = 1'b0;
    rf_we       = 1'b0;
    rf_waddr    = dst;
    rf_wdata    = alu_sum[DATA_W-1:0];
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD_B;
        end
      end

      ST_RD_B: begin
        a_d     = in_q.left_is_literal ? {1'b0, in_q.left_literal} : rdata_q;
        state_d = ST_EXEC;
      end

      ST_EXEC: begin
        hold_d   = 1'b0;
        take_d   = 1'b0;
        status_d = STAT_OK;
        pvalid_d = 1'b0;
        pchar_d  = 1'b0;
        pval_d   = '0;
        state_d  = ST_FINISH;
        if (index_q >= len_eff) begin
          hold_d = 1'b1;
        end else begin
          case (in_q.operation) inside
            OP_MOV, OP_ADD, OP_SUB: begin
              alu_a   = {1'b0, a_q};
              alu_b   = {1'b0, b_val};
              alu_sub = (in_q.operation == OP_SUB);
              if (in_q.left_is_literal) begin
                status_d = STAT_LIT_DST;
                hold_d   = 1'b1;
              end else begin
                rf_we    = 1'b1;
                rf_wdata = (in_q.operation == OP_MOV) ? b_val : alu_sum[DATA_W-1:0];
              end
            end
            OP_MUL: begin
              work_d  = '0;
              opnd_d  = a_q;
              shift_d = b_val;
              cnt_d   = '0;
              state_d = ST_MUL;
            end
            OP_DIV: begin
              // magnitude of the dividend
              alu_b   = {1'b0, a_q};
              alu_sub = a_q[DATA_W-1];
              if (b_val == '0) begin
                status_d = STAT_DIV_ZERO;
                hold_d   = 1'b1;
              end else begin
                shift_d = alu_sum[DATA_W-1:0];
                opnd_d  = b_val;
                neg_d   = a_q[DATA_W-1] ^ b_val[DATA_W-1];
                work_d  = '0;
                state_d = ST_DIV_PREP;
              end
            end
            OP_CMP: begin
              // sign-extended difference, no overflow
              alu_a   = {a_q[DATA_W-1], a_q};
              alu_b   = {b_val[DATA_W-1], b_val};
              alu_sub = 1'b1;
              zero_d  = (alu_sum == '0);
              less_d  = alu_sum[DATA_W];
            end
            OP_JMP: take_d = 1'b1;
            OP_JE:  take_d = zero_q;
            OP_JG:  take_d = !less_q && !zero_q;
            OP_JL:  take_d = less_q;
            OP_JNE: take_d = !zero_q;
            OP_JGE: take_d = zero_q || !less_q;
            OP_JLE: take_d = zero_q || less_q;
            OP_PRINTINT: begin
              pvalid_d = 1'b1;
              pval_d   = a_q;
            end
            OP_PRINTCHAR: begin
              pvalid_d = 1'b1;
              pchar_d  = 1'b1;
              pval_d   = {{(DATA_W-8){1'b0}}, a_q[7:0]};
            end
            default: begin
            end
          endcase
        end
      end

      // Shift-add multiply, one multiplier bit per cycle
      ST_MUL: begin
        alu_a   = {1'b0, work_q};
        alu_b   = {1'b0, opnd_q};
        if (shift_q[0]) begin
          work_d = alu_sum[DATA_W-1:0];
        end
        opnd_d  = {opnd_q[DATA_W-2:0], 1'b0};
        shift_d = {1'b0, shift_q[DATA_W-1:1]};
        cnt_d   = cnt_q + STEP_CNT_W'(1);
        if (cnt_q == STEP_CNT_W'(DATA_W - 1)) begin
          rf_we    = 1'b1;
          rf_waddr = REG_ADDR_W'(REG_COUNT - 1);
          rf_wdata = shift_q[0] ? alu_sum[DATA_W-1:0] : work_q;
          state_d  = ST_FINISH;
        end
      end

      // Magnitude of the divisor
      ST_DIV_PREP: begin
        alu_b   = {1'b0, opnd_q};
        alu_sub = opnd_q[DATA_W-1];
        opnd_d  = alu_sum[DATA_W-1:0];
        cnt_d   = '0;
        state_d = ST_DIV;
      end

      // Restoring division, one quotient bit per cycle
      ST_DIV: begin
        alu_a   = {work_q, shift_q[DATA_W-1]};
        alu_b   = {1'b0, opnd_q};
        alu_sub = 1'b1;
        if (!alu_sum[DATA_W]) begin
          work_d  = alu_sum[DATA_W-1:0];
          shift_d = {shift_q[DATA_W-2:0], 1'b1};
        end else begin
          work_d  = alu_a[DATA_W-1:0];
          shift_d = {shift_q[DATA_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + STEP_CNT_W'(1);
        if (cnt_q == STEP_CNT_W'(DATA_W - 1)) begin
          state_d = ST_DIV_FIX;
        end
      end

      // Apply quotient sign and write r5
      ST_DIV_FIX: begin
        alu_b    = {1'b0, shift_q};
        alu_sub  = neg_q;
        rf_we    = 1'b1;
        rf_waddr = REG_ADDR_W'(REG_COUNT - 1);
        rf_wdata = alu_sum[DATA_W-1:0];
        state_d  = ST_FINISH;
      end

      // Register the result once the output slot is free
      ST_FINISH: begin
        if (!out_valid_q || result_o.ready) begin
          out_load          = 1'b1;
          index_d           = next_idx;
          out_d.next_index  = next_idx;
          out_d.program_done = (next_idx >= len_eff);
          out_d.print_valid = pvalid_q;
          out_d.print_is_char = pchar_q;
          out_d.print_value = pval_q;
          out_d.status      = status_q;
          state_d           = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // State register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      index_q     <= '0;
      len_q       <= LEN_RESET;
      zero_q      <= 1'b0;
      less_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      index_q     <= index_d;
      zero_q      <= zero_d;
      less_q      <= less_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  // Register file: one write port, one registered read port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_q[i] <= '0;
      end
    end else if (rf_we) begin
      rf_q[rf_waddr] <= rf_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rf_q[rd_addr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i.payload;
    end
    a_q      <= a_d;
    work_q   <= work_d;
    opnd_q   <= opnd_d;
    shift_q  <= shift_d;
    neg_q    <= neg_d;
    hold_q   <= hold_d;
    take_q   <= take_d;
    status_q <= status_d;
    pvalid_q <= pvalid_d;
    pchar_q  <= pchar_d;
    pval_q   <= pval_d;
    out_q    <= out_d;
  end

  // Assertions
  a_load_in_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> state_q == ST_FINISH)
    else $error("result loaded outside finish state");

  a_error_holds_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && status_q != STAT_OK) |=> index_q == $past(index_q))
    else $error("program index moved on an error");

  a_no_print_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.print_valid) |->
      (!out_q.print_is_char && out_q.print_value == '0))
    else $error("print fields set without a print");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV) |-> !item_i.ready)
    else $error("instruction accepted during iteration");

endmodule

// File: dv/tb_register_machine_execute_unit_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Execute unit testbench
// Drives decoded instructions into the register machine execute unit through
// a directed table and then random programs across several program lengths
// and idling patterns. Every result transaction is checked field by field against
// a typed table result or an in-bench machine model tracking registers, flags and index.
// ----------------------------------------------------------------------------
module tb_register_machine_execute_unit_top;
  import rmeu_pkg::*;

  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 50;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam out_item_t   NO_RESULT      = '0;

  // One row of the directed stimulus table
  typedef struct packed {
    logic               cfg_write;
    logic [INDEX_W-1:0] cfg_len;
    in_item_t           ins;
    logic               typed;
    out_item_t          res;
  } step_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [INDEX_W-1:0] cfg_wdata_i;

  rmeu_in_if  item_if ();
  rmeu_out_if result_if ();

  register_machine_execute_unit_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  // Machine model state
  logic [DATA_W-1:0]  mach_regs [REG_COUNT];
  logic               mach_zf;
  logic               mach_lf;
  logic [INDEX_W-1:0] mach_idx;
  logic [INDEX_W-1:0] mach_len;

  out_item_t   expected_results [$];
  step_row_t   dir_steps [$];
  out_item_t   want;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [INDEX_W-1:0] eff_len();
    return (mach_len > INDEX_W'(PROGRAM_DEPTH)) ? INDEX_W'(PROGRAM_DEPTH) : mach_len;
  endfunction

  function automatic int unsigned reg_slot(logic [REG_SEL_W-1:0] r);
    return (r > 3'd4) ? 4 : int'(r);
  endfunction

  // Machine model: executes one instruction and returns its result
  function automatic out_item_t execute_instr(in_item_t ins);
    out_item_t          res;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
    logic [DATA_W-1:0]  ma;
    logic [DATA_W-1:0]  mb;
    logic [DATA_W-1:0]  q;
    logic signed [32:0] diff;
    int unsigned        dst;
    logic               take;
    logic [INDEX_W:0]   nxt;
    res = NO_RESULT;
    res.status = STAT_OK;
    take = 1'b0;
    // Finished program: instruction ignored
    if (mach_idx >= eff_len()) begin
      res.next_index   = mach_idx;
      res.program_done = 1'b1;
      return res;
    end
    a = ins.left_is_literal ? {1'b0, ins.left_literal} : mach_regs[reg_slot(ins.left_reg)];
    b = ins.right_is_literal ? {1'b0, ins.right_literal} : mach_regs[reg_slot(ins.right_reg)];
    dst = reg_slot(ins.left_reg);
    case (ins.operation) inside
      OP_MOV, OP_ADD, OP_SUB: begin
        if (ins.left_is_literal) begin
          res.status = STAT_LIT_DST;
        end else if (ins.operation == OP_MOV) begin
          mach_regs[dst] = b;
        end else if (ins.operation == OP_ADD) begin
          mach_regs[dst] = mach_regs[dst] + b;
        end else begin
          mach_regs[dst] = mach_regs[dst] - b;
        end
      end
      OP_MUL: mach_regs[4] = a * b;
      OP_DIV: begin
        if (b == '0) begin
          res.status = STAT_DIV_ZERO;
        end else begin
          // truncating signed divide on magnitudes; overflow wraps
          ma = a[31] ? (32'd0 - a) : a;
          mb = b[31] ? (32'd0 - b) : b;
          q  = ma / mb;
          mach_regs[4] = (a[31] ^ b[31]) ? (32'd0 - q) : q;
        end
      end
      OP_CMP: begin
        diff    = $signed({a[31], a}) - $signed({b[31], b});
        mach_zf = (diff == '0);
        mach_lf = diff[32];
      end
      OP_JMP: take = 1'b1;
      OP_JE:  take = mach_zf;
      OP_JG:  take = !mach_lf && !mach_zf;
      OP_JL:  take = mach_lf;
      OP_JNE: take = !mach_zf;
      OP_JGE: take = mach_zf || !mach_lf;
      OP_JLE: take = mach_zf || mach_lf;
      OP_PRINTINT: begin
        res.print_valid = 1'b1;
        res.print_value = a;
      end
      OP_PRINTCHAR: begin
        res.print_valid   = 1'b1;
        res.print_is_char = 1'b1;
        res.print_value   = {24'd0, a[7:0]};
      end
      default: ;
    endcase
    // Error holds the index; taken jump lands just past the label
    if (res.status != STAT_OK) begin
      nxt = {1'b0, mach_idx};
    end else if (take) begin
      nxt = {2'b0, ins.jump_target} + 12'd1;
    end else begin
      nxt = {1'b0, mach_idx} + 12'd1;
    end
    mach_idx = nxt[INDEX_W-1:0];
    res.next_index   = mach_idx;
    res.program_done = (mach_idx >= eff_len());
    return res;
  endfunction

  function automatic in_item_t instr_of(op_e op, logic [2:0] lr, logic llit_en,
                                        logic [30:0] llit, logic [2:0] rr,
                                        logic rlit_en, logic [30:0] rlit,
                                        logic [9:0] tgt);
    in_item_t ins;
    ins.operation        = op;
    ins.left_reg         = lr;
    ins.left_is_literal  = llit_en;
    ins.left_literal     = llit;
    ins.right_reg        = rr;
    ins.right_is_literal = rlit_en;
    ins.right_literal    = rlit;
    ins.jump_target      = tgt;
    return ins;
  endfunction

  function automatic out_item_t result_of(logic [10:0] nxt, logic done, logic pv,
                                          logic pc, logic [31:0] val, status_e st);
    out_item_t res;
    res.next_index    = nxt;
    res.program_done  = done;
    res.print_valid   = pv;
    res.print_is_char = pc;
    res.print_value   = val;
    res.status        = st;
    return res;
  endfunction

  // Append one row to the directed table
  function automatic void add_step(step_row_t row);
    dir_steps = {dir_steps, row};
  endfunction

  // Literal values biased toward the edges
  function automatic logic [LIT_W-1:0] rand_literal();
    int unsigned pick;
    pick = $urandom_range(7);
    case (pick) inside
      0:       return '0;
      1:       return '1;
      2, 3:    return LIT_W'($urandom_range(15));
      default: return LIT_W'($urandom);
    endcase
  endfunction

  // Random instruction that keeps the program running most of the time
  function automatic in_item_t random_instr();
    in_item_t           ins;
    logic [INDEX_W-1:0] len;
    logic               is_jump;
    len = eff_len();
    ins.operation = ($urandom_range(99) < 10) ? OP_CMP : op_e'(4'($urandom_range(15)));
    if ({1'b0, mach_idx} + 12'd1 >= {1'b0, len}) begin
      ins.operation = OP_JMP;
    end
    ins.left_reg         = 3'($urandom_range(7));
    ins.right_reg        = 3'($urandom_range(7));
    ins.left_literal     = rand_literal();
    ins.right_literal    = rand_literal();
    ins.right_is_literal = 1'($urandom_range(1));
    if (ins.operation inside {OP_MOV, OP_ADD, OP_SUB}) begin
      ins.left_is_literal = ($urandom_range(9) == 0);
    end else begin
      ins.left_is_literal = ($urandom_range(2) == 0);
    end
    is_jump = (ins.operation >= OP_JMP) && (ins.operation <= OP_JLE);
    if (!is_jump) begin
      ins.jump_target = 10'($urandom_range(1023));
    end else if (len < INDEX_W'(PROGRAM_DEPTH) && $urandom_range(149) == 0) begin
      // land exactly on the end of the program
      ins.jump_target = 10'(len - 1);
    end else begin
      ins.jump_target = (len >= 2) ? 10'($urandom_range(len - 2)) : '0;
    end
    return ins;
  endfunction

  // Offer one instruction; record its expectation on acceptance
  task automatic issue_instr(in_item_t ins, logic typed, out_item_t given);
    out_item_t   pred;
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= ins;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    pred = execute_instr(ins);
    expected_results = {expected_results, (typed ? given : pred)};
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic set_program_length(logic [INDEX_W-1:0] len);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mach_len = len;
  endtask

  // Rewind to the start of the program, then apply the new length
  task automatic begin_phase(logic [INDEX_W-1:0] len, int unsigned gp, int unsigned sp);
    if (mach_idx >= eff_len()) begin
      set_program_length(INDEX_W'(PROGRAM_DEPTH));
    end
    issue_instr(instr_of(OP_JMP, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd0), 1'b0, NO_RESULT);
    set_program_length(len);
    gap_pct   = gp;
    stall_pct = sp;
  endtask

  task automatic run_random_program(int unsigned n, logic pressure);
    int unsigned sent;
    sent = 0;
    while (sent < n) begin
      if (mach_idx >= eff_len()) begin
        // one ignored instruction past the end, then stop
        issue_instr(random_instr(), 1'b0, NO_RESULT);
        break;
      end
      issue_instr(random_instr(), 1'b0, NO_RESULT);
      sent++;
      if (pressure && sent == 40) hold_req++;
      if (pressure && sent == 90) drain_results();
    end
  endtask

  // Result sink: random stalls plus an occasional long hold-off
  initial begin
    result_if.ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("%0t: unexpected result transaction next=%0d", $realtime,
                   result_if.payload.next_index);
        end
      end else begin
        want = expected_results.pop_front();
        if (result_if.payload.next_index    !== want.next_index    ||
            result_if.payload.program_done  !== want.program_done  ||
            result_if.payload.print_valid   !== want.print_valid   ||
            result_if.payload.print_is_char !== want.print_is_char ||
            result_if.payload.print_value   !== want.print_value   ||
            result_if.payload.status        !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: mismatch exp next=%0d done=%0b pv=%0b pc=%0b val=%h st=%0d",
                     $realtime, want.next_index, want.program_done, want.print_valid,
                     want.print_is_char, want.print_value, want.status);
            $display("%0t:          got next=%0d done=%0b pv=%0b pc=%0b val=%h st=%0d",
                     $realtime, result_if.payload.next_index,
                     result_if.payload.program_done, result_if.payload.print_valid,
                     result_if.payload.print_is_char, result_if.payload.print_value,
                     result_if.payload.status);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    item_if.valid   <= 1'b0;
    item_if.payload <= '0;
    gap_pct         = 0;
    stall_pct       = 0;
    hold_req        = 0;
    foreach (mach_regs[i]) mach_regs[i] = '0;
    mach_zf  = 1'b0;
    mach_lf  = 1'b0;
    mach_idx = '0;
    mach_len = LEN_RESET;

    // Directed table: reset length of one, then every operation and corner
    add_step('{1'b0, 11'd0,
      instr_of(OP_PRINTINT, 3'd0, 1'b1, '1, 3'd0, 1'b0, '0, 10'd0),
      1'b1, result_of(11'd1, 1'b1, 1'b1, 1'b0, 32'h7FFF_FFFF, STAT_OK)});
    add_step('{1'b0, 11'd0,
      instr_of(OP_MOV, 3'd0, 1'b0, '0, 3'd0, 1'b1, 31'd5, 10'd0),
      1'b1, result_of(11'd1, 1'b1, 1'b0, 1'b0, 32'd0, STAT_OK)});
    add_step('{1'b1, 11'd0,
      instr_of(OP_ADD, 3'd7, 1'b0, '0, 3'd7, 1'b0, '0, 10'd1023),
      1'b1, result_of(11'd1, 1'b1, 1'b0, 1'b0, 32'd0, STAT_OK)});
    add_step('{1'b1, 11'd2047,
      instr_of(OP_MOV, 3'd0, 1'b0, '0, 3'd0, 1'b1, '1, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_MOV, 3'd1, 1'b1, 31'd9, 3'd0, 1'b1, 31'd3, 10'd0),
      1'b1, result_of(11'd2, 1'b0, 1'b0, 1'b0, 32'd0, STAT_LIT_DST)});
    add_step('{1'b0, 11'd0,
      instr_of(OP_ADD, 3'd0, 1'b0, '0, 3'd0, 1'b1, 31'd1, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_SUB, 3'd2, 1'b0, '0, 3'd0, 1'b1, 31'd1, 10'd0), 1'b0, NO_RESULT});
    // most negative divided by minus one
    add_step('{1'b0, 11'd0,
      instr_of(OP_DIV, 3'd0, 1'b0, '0, 3'd2, 1'b0, '0, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_DIV, 3'd0, 1'b1, 31'd7, 3'd0, 1'b1, '0, 10'd0),
      1'b1, result_of(11'd5, 1'b0, 1'b0, 1'b0, 32'd0, STAT_DIV_ZERO)});
    add_step('{1'b0, 11'd0,
      instr_of(OP_DIV, 3'd0, 1'b0, '0, 3'd3, 1'b0, '0, 10'd0),
      1'b1, result_of(11'd5, 1'b0, 1'b0, 1'b0, 32'd0, STAT_DIV_ZERO)});
    add_step('{1'b0, 11'd0,
      instr_of(OP_MUL, 3'd0, 1'b1, '1, 3'd2, 1'b0, '0, 10'd0), 1'b0, NO_RESULT});
    // register selects above r5 fold onto r5
    add_step('{1'b0, 11'd0,
      instr_of(OP_MOV, 3'd6, 1'b0, '0, 3'd0, 1'b1, 31'h12345, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_PRINTCHAR, 3'd5, 1'b0, '0, 3'd0, 1'b0, '0, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_PRINTINT, 3'd0, 1'b0, '0, 3'd7, 1'b0, '0, 10'd0), 1'b0, NO_RESULT});
    // compare across the signed overflow boundary
    add_step('{1'b0, 11'd0,
      instr_of(OP_CMP, 3'd0, 1'b1, '1, 3'd0, 1'b0, '0, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_JG, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd20), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_JL, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd3), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_CMP, 3'd0, 1'b0, '0, 3'd2, 1'b0, '0, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_JLE, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_JGE, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd500), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_CMP, 3'd0, 1'b1, '0, 3'd0, 1'b1, '0, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_JE, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd9), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_JNE, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd0), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_JMP, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd1021), 1'b0, NO_RESULT});
    add_step('{1'b0, 11'd0,
      instr_of(OP_NOP, 3'd7, 1'b1, '1, 3'd7, 1'b1, '1, 10'd1023), 1'b0, NO_RESULT});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_steps[i]) begin
      if (dir_steps[i].cfg_write) set_program_length(dir_steps[i].cfg_len);
      issue_instr(dir_steps[i].ins, dir_steps[i].typed, dir_steps[i].res);
    end

    // Random programs over several lengths and idling patterns
    begin_phase(11'd1024, 0, 0);
    run_random_program(150, 1'b0);
    begin_phase(11'd2047, 61, 0);
    run_random_program(140, 1'b0);
    begin_phase(11'd64, 0, 61);
    run_random_program(140, 1'b0);
    begin_phase(11'd2, 19, 19);
    run_random_program(60, 1'b0);
    begin_phase(11'd600, 0, 0);
    run_random_program(150, 1'b1);
    begin_phase(11'd1000, 19, 19);
    run_random_program(60, 1'b0);

    // Jump to the last label index: the program ends for good
    drain_results();
    if (mach_idx >= eff_len()) set_program_length(11'd2047);
    set_program_length(11'd2047);
    gap_pct   = 0;
    stall_pct = 0;
    issue_instr(instr_of(OP_JMP, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd1023), 1'b0,
                NO_RESULT);
    issue_instr(instr_of(OP_PRINTINT, 3'd0, 1'b0, '0, 3'd0, 1'b0, '0, 10'd0), 1'b0,
                NO_RESULT);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
src/rmeu_pkg.sv
src/rmeu_in_if.sv
src/rmeu_out_if.sv
src/register_machine_execute_unit_top.sv
dv/tb_register_machine_execute_unit_top.sv
